FILE: design/soil_moisture_conditioner_macros.svh
// Assertion macros shared by the soil moisture conditioner RTL.
// Needs signals named clock and reset in the including module; define ASSERT_OFF to drop them.
`ifndef SOIL_MOISTURE_CONDITIONER_MACROS_SVH
`define SOIL_MOISTURE_CONDITIONER_MACROS_SVH
`ifndef ASSERT_OFF
`define SMC_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define SMC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`define SMC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define SMC_ASSERT(lbl, expr, msg)
`define SMC_ASSERT_IMP(lbl, ante, cons, msg)
`define SMC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/smc_pkg.sv
// Shared constants, types and state codes of the soil moisture conditioner.
// No dependencies; every RTL module imports it.
`default_nettype none

package smc_pkg;

   localparam int ADC_W        = 12;
   localparam int GROUP_SIZE   = 12;
   localparam int GROUP_CNT_W  = $clog2(GROUP_SIZE + 1);
   localparam int GROUP_SUM_W  = $clog2(GROUP_SIZE * ((1 << ADC_W) - 1) + 1);

   localparam int RING_DEPTH   = 10;
   localparam int RING_IDX_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int RING_FILL_W  = $clog2(RING_DEPTH + 1);

   localparam int PCT_FULL     = 100;
   localparam int PCT_W        = $clog2(PCT_FULL + 1);
   localparam int RING_SUM_W   = $clog2(RING_DEPTH * PCT_FULL + 1);

   localparam int FRAC_BITS    = 8;
   localparam int Q8_W         = 15;
   localparam int PROD_W       = $clog2(((1 << ADC_W) - 1) * PCT_FULL + 1);

   localparam int DIV_A_W      = (GROUP_SUM_W > PROD_W) ? GROUP_SUM_W : PROD_W;
   localparam int DIV_NUM_W    = (DIV_A_W > RING_SUM_W + FRAC_BITS) ?
                                 DIV_A_W : RING_SUM_W + FRAC_BITS;
   localparam int DIV_DEN_W    = ADC_W;
   localparam int DIV_CNT_W    = $clog2(DIV_NUM_W + 1);

   localparam int CSR_IDX_W    = 1;

   localparam logic [ADC_W-1:0] CAL_DRY_RESET = 12'd3550;
   localparam logic [ADC_W-1:0] CAL_WET_RESET = 12'd1855;
   localparam logic [ADC_W-1:0] AVG_LOW_LIMIT = 12'd1400;
   localparam logic [ADC_W-1:0] AVG_HIGH_LIMIT = 12'd3900;
   localparam logic [ADC_W-1:0] SPREAD_LIMIT  = 12'd900;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_DRY = 1'b0,
      CSR_CAL_WET = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_CHECK,
      ST_PCT_GO,
      ST_PCT_WAIT,
      ST_PUSH,
      ST_PUSH_WAIT,
      ST_OUT_GO,
      ST_OUT_WAIT,
      ST_EMIT
   } smc_state_type;

   typedef struct packed {
      logic                   done;
      logic [GROUP_SUM_W-1:0] sum;
      logic [ADC_W-1:0]       spread;
   } grp_result_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_stat_type;

   typedef struct packed {
      logic             push;
      logic             clear;
      logic [PCT_W-1:0] pct;
   } ring_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [RING_SUM_W-1:0] sum;
      logic [RING_FILL_W-1:0] fill;
   } ring_stat_type;

endpackage

`default_nettype wire

FILE: design/soil_moisture_conditioner.sv
// Top level of the soil moisture conditioner: stream ports, calibration registers, sequencer.
// Depends on smc_pkg, smc_group, smc_div, smc_ring and the assertion macro header.
`default_nettype none
`include "soil_moisture_conditioner_macros.svh"

// Soil moisture conditioner. Each request carries one 12-bit ADC sample. Samples are
// grouped by twelve; the first eleven of a group are taken in one cycle each and give no
// response. The twelfth closes the group and produces exactly one response. Ready then
// drops while the sequencer works on the group with the one shared 19-step divider.
// A connected group runs three divisions (group average, linear calibration map,
// moving-average mean) and one read-modify-write of the 10-entry percent ring memory;
// ready stays low until the response is loaded into the output register. With an
// equal calibration pair the map division is skipped. A disconnected group needs only
// the average. A response that is not taken waits in the output
// register while the next group is collected; the following group then holds ready low
// until that register frees up. A group whose average is below 1400, at or above 3900,
// or whose spread is 900 or more gives moisture 0 with the disconnected flag set and
// empties the moving average. Writing either calibration register also empties the moving
// average; write them only while no group is closing.
module soil_moisture_conditioner
   import smc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // [11:0] adc_sample, [15:12] zero
   // response stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // [14:0] moisture_q8, [15] zero
   output logic                 rsp_tuser,   // [0] disconnected
   // calibration register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADC_W-1:0]     csr_wdata
);

   smc_state_type        state_ff, state_in;
   logic [ADC_W-1:0]     cal_dry_ff, cal_dry_in;
   logic [ADC_W-1:0]     cal_wet_ff, cal_wet_in;

   logic [ADC_W-1:0]     avg_ff, avg_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [ADC_W-1:0]     abs_span_ff, abs_span_in;
   logic                 neg_ff, neg_in;
   logic [PCT_W-1:0]     pct_ff, pct_in;
   logic [Q8_W-1:0]      res_q8_ff, res_q8_in;
   logic                 res_disc_ff, res_disc_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [Q8_W-1:0]      rsp_q8_ff, rsp_q8_in;
   logic                 rsp_disc_ff, rsp_disc_in;

   logic                 accept;
   logic                 load_rsp;
   logic                 disc;
   logic [ADC_W:0]       diff;
   logic [ADC_W:0]       span;
   logic [ADC_W-1:0]     abs_diff;
   logic [ADC_W-1:0]     abs_span;

   grp_result_type       grp;
   div_cmd_type          div_cmd;
   div_stat_type         div_stat;
   ring_cmd_type         ring_cmd;
   ring_stat_type        ring_stat;

   // hold off new samples while a closed group is being worked on
   assign req_tready = (state_ff == ST_COLLECT) && !grp.done;
   assign accept     = req_tvalid && req_tready;

   smc_group u_group (
      .clock        (clock),
      .reset        (reset),
      .sample_valid (accept),
      .sample       (req_tdata[ADC_W-1:0]),
      .result       (grp)
   );

   smc_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   smc_ring u_ring (
      .clock (clock),
      .reset (reset),
      .cmd   (ring_cmd),
      .stat  (ring_stat)
   );

   // calibration registers
   always_comb begin
      cal_dry_in = cal_dry_ff;
      cal_wet_in = cal_wet_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CAL_DRY: cal_dry_in = csr_wdata;
            CSR_CAL_WET: cal_wet_in = csr_wdata;
            default:     cal_dry_in = cal_dry_ff;
         endcase
      end
   end

   // group checks and the signed calibration offsets
   always_comb begin
      disc     = (avg_ff < AVG_LOW_LIMIT) || (avg_ff >= AVG_HIGH_LIMIT) ||
                 (grp.spread >= SPREAD_LIMIT);
      diff     = {1'b0, avg_ff} - {1'b0, cal_dry_ff};
      span     = {1'b0, cal_wet_ff} - {1'b0, cal_dry_ff};
      abs_diff = diff[ADC_W] ? ADC_W'(-diff) : diff[ADC_W-1:0];
      abs_span = span[ADC_W] ? ADC_W'(-span) : span[ADC_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      avg_in      = avg_ff;
      prod_in     = prod_ff;
      abs_span_in = abs_span_ff;
      neg_in      = neg_ff;
      pct_in      = pct_ff;
      res_q8_in   = res_q8_ff;
      res_disc_in = res_disc_ff;
      load_rsp    = 1'b0;
      div_cmd     = '0;
      ring_cmd    = '0;
      ring_cmd.pct   = pct_ff;
      ring_cmd.clear = csr_we;
      unique case (state_ff)
         ST_COLLECT: begin
            if (grp.done) begin
               state_in = ST_AVG_GO;
            end
         end
         ST_AVG_GO: begin
            div_cmd.start = 1'b1;
            div_cmd.num   = DIV_NUM_W'(grp.sum);
            div_cmd.den   = DIV_DEN_W'(GROUP_SIZE);
            state_in      = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_stat.done) begin
               avg_in   = div_stat.quo[ADC_W-1:0];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (disc) begin
               // unplugged sensor: report zero and empty the window
               ring_cmd.clear = 1'b1;
               res_q8_in      = '0;
               res_disc_in    = 1'b1;
               state_in       = ST_EMIT;
            end else if (span == '0) begin
               pct_in   = '0;
               state_in = ST_PUSH;
            end else begin
               prod_in     = PROD_W'(abs_diff) * PROD_W'(PCT_FULL);
               abs_span_in = abs_span;
               neg_in      = diff[ADC_W] ^ span[ADC_W];
               state_in    = ST_PCT_GO;
            end
         end
         ST_PCT_GO: begin
            div_cmd.start = 1'b1;
            div_cmd.num   = DIV_NUM_W'(prod_ff);
            div_cmd.den   = abs_span_ff;
            state_in      = ST_PCT_WAIT;
         end
         ST_PCT_WAIT: begin
            if (div_stat.done) begin
               // a negative quotient clamps to zero, anything above full scale to full scale
               if (neg_ff) begin
                  pct_in = '0;
               end else if (div_stat.quo > DIV_NUM_W'(PCT_FULL)) begin
                  pct_in = PCT_W'(PCT_FULL);
               end else begin
                  pct_in = div_stat.quo[PCT_W-1:0];
               end
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            ring_cmd.push = 1'b1;
            state_in      = ST_PUSH_WAIT;
         end
         ST_PUSH_WAIT: begin
            if (ring_stat.done) begin
               state_in = ST_OUT_GO;
            end
         end
         ST_OUT_GO: begin
            div_cmd.start = 1'b1;
            div_cmd.num   = DIV_NUM_W'({ring_stat.sum, {FRAC_BITS{1'b0}}});
            div_cmd.den   = DIV_DEN_W'(ring_stat.fill);
            state_in      = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (div_stat.done) begin
               res_q8_in   = div_stat.quo[Q8_W-1:0];
               res_disc_in = 1'b0;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_q8_in    = rsp_q8_ff;
      rsp_disc_in  = rsp_disc_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_q8_in    = res_q8_ff;
         rsp_disc_in  = res_disc_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         cal_dry_ff   <= CAL_DRY_RESET;
         cal_wet_ff   <= CAL_WET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cal_dry_ff   <= cal_dry_in;
         cal_wet_ff   <= cal_wet_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff      <= avg_in;
      prod_ff     <= prod_in;
      abs_span_ff <= abs_span_in;
      neg_ff      <= neg_in;
      pct_ff      <= pct_in;
      res_q8_ff   <= res_q8_in;
      res_disc_ff <= res_disc_in;
      rsp_q8_ff   <= rsp_q8_in;
      rsp_disc_ff <= rsp_disc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_q8_ff};
   assign rsp_tuser  = rsp_disc_ff;

   `SMC_ASSERT_IMP(a_disc_reports_zero, rsp_valid_ff && rsp_disc_ff, rsp_q8_ff == '0, "disconnected response with nonzero moisture")
   `SMC_ASSERT_NEXT(a_emit_loads_output, state_ff == ST_EMIT && (!rsp_valid_ff || rsp_tready), rsp_valid_ff && state_ff == ST_COLLECT, "finished result not loaded")
   `SMC_ASSERT_IMP(a_div_start_idle, div_cmd.start, !div_stat.busy, "divider restarted while busy")

endmodule

`default_nettype wire

FILE: design/smc_group.sv
// Sample group accumulator: running sum, minimum and maximum over one group.
// Depends on smc_pkg.
`default_nettype none

module smc_group
   import smc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             sample_valid,
   input  logic [ADC_W-1:0] sample,
   output grp_result_type   result
);

   logic [GROUP_CNT_W-1:0] count_ff, count_in;
   logic [GROUP_SUM_W-1:0] sum_ff, sum_in;
   logic [ADC_W-1:0]       min_ff, min_in;
   logic [ADC_W-1:0]       max_ff, max_in;
   logic                   done_ff, done_in;
   logic [GROUP_SUM_W-1:0] fin_sum_ff, fin_sum_in;
   logic [ADC_W-1:0]       fin_spread_ff, fin_spread_in;

   logic [GROUP_SUM_W-1:0] sum_add;
   logic [ADC_W-1:0]       min_upd;
   logic [ADC_W-1:0]       max_upd;

   always_comb begin
      sum_add       = sum_ff + GROUP_SUM_W'(sample);
      min_upd       = (sample < min_ff) ? sample : min_ff;
      max_upd       = (sample > max_ff) ? sample : max_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      done_in       = 1'b0;
      fin_sum_in    = fin_sum_ff;
      fin_spread_in = fin_spread_ff;
      if (sample_valid) begin
         if (count_ff == GROUP_CNT_W'(GROUP_SIZE - 1)) begin
            // close the group and start a fresh one
            done_in       = 1'b1;
            fin_sum_in    = sum_add;
            fin_spread_in = max_upd - min_upd;
            count_in      = '0;
            sum_in        = '0;
            min_in        = '1;
            max_in        = '0;
         end else begin
            count_in = count_ff + 1'b1;
            sum_in   = sum_add;
            min_in   = min_upd;
            max_in   = max_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         min_ff   <= '1;
         max_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_sum_ff    <= fin_sum_in;
      fin_spread_ff <= fin_spread_in;
   end

   assign result.done   = done_ff;
   assign result.sum    = fin_sum_ff;
   assign result.spread = fin_spread_ff;

endmodule

`default_nettype wire

FILE: design/smc_div.sv
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on smc_pkg.
`default_nettype none

module smc_div
   import smc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_stat_type stat
);

   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   trial_sub;
   logic                 fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[DIV_NUM_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits      = trial >= {1'b0, den_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (cmd.start) begin
         quo_in  = cmd.num;
         rem_in  = '0;
         den_in  = cmd.den;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.quo  = quo_ff;

endmodule

`default_nettype wire

FILE: design/smc_ring.sv
// Moving-average window: percent ring memory with read-modify-write of the running sum.
// Depends on smc_pkg and the assertion macro header.
`default_nettype none
`include "soil_moisture_conditioner_macros.svh"

module smc_ring
   import smc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ring_cmd_type  cmd,
   output ring_stat_type stat
);

   logic [PCT_W-1:0]       mem [RING_DEPTH];
   logic [PCT_W-1:0]       rd_data_ff;

   logic [RING_IDX_W-1:0]  idx_ff, idx_in;
   logic [RING_FILL_W-1:0] fill_ff, fill_in;
   logic [RING_SUM_W-1:0]  sum_ff, sum_in;
   logic                   pend_ff, pend_in;
   logic                   done_ff;
   logic [PCT_W-1:0]       pct_ff, pct_in;

   logic [RING_IDX_W-1:0]  base_idx;
   logic [RING_FILL_W-1:0] base_fill;
   logic [RING_SUM_W-1:0]  base_sum;
   logic                   full;
   logic                   wr_en;

   always_comb begin
      // a clear in the write cycle acts first, so the push lands in an empty window
      base_idx  = cmd.clear ? '0 : idx_ff;
      base_fill = cmd.clear ? '0 : fill_ff;
      base_sum  = cmd.clear ? '0 : sum_ff;
      full      = base_fill == RING_FILL_W'(RING_DEPTH);
      wr_en     = pend_ff;
      pend_in   = cmd.push;
      pct_in    = cmd.push ? cmd.pct : pct_ff;
      idx_in    = base_idx;
      fill_in   = base_fill;
      sum_in    = base_sum;
      if (pend_ff) begin
         sum_in = base_sum - (full ? RING_SUM_W'(rd_data_ff) : '0) + RING_SUM_W'(pct_ff);
         if (!full) begin
            fill_in = base_fill + 1'b1;
         end
         if (base_idx == RING_IDX_W'(RING_DEPTH - 1)) begin
            idx_in = '0;
         end else begin
            idx_in = base_idx + 1'b1;
         end
      end
   end

   // read the outgoing entry on push, write the new percent in the following cycle
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rd_data_ff <= mem[idx_ff];
      end
      if (wr_en) begin
         mem[base_idx] <= pct_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
         pend_ff <= pend_in;
         done_ff <= pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      pct_ff <= pct_in;
   end

   assign stat.done = done_ff;
   assign stat.sum  = sum_ff;
   assign stat.fill = fill_ff;

   `SMC_ASSERT(a_ring_fill_max, fill_ff <= RING_FILL_W'(RING_DEPTH), "ring fill beyond depth")
   `SMC_ASSERT_IMP(a_ring_idx_tracks_fill, fill_ff != RING_FILL_W'(RING_DEPTH), RING_FILL_W'(idx_ff) == fill_ff, "ring index out of step with fill")
   `SMC_ASSERT_NEXT(a_ring_done_follows, pend_ff, done_ff && fill_ff != '0, "ring update missing or empty")

endmodule

`default_nettype wire
